// ===== rtl/hfc_pkg.sv =====
package hfc_pkg;

   // Codes of the clip status field.
   localparam logic [1:0] CLIP_NONE = 2'd0;
   localparam logic [1:0] CLIP_LOW  = 2'd1;
   localparam logic [1:0] CLIP_HIGH = 2'd2;

   // Register indexes on the configuration port.
   localparam logic REG_LOW_LIMIT  = 1'b0;
   localparam logic REG_HIGH_LIMIT = 1'b1;

   localparam logic signed [15:0] LOW_LIMIT_RESET  = 16'sd2000;
   localparam logic signed [15:0] HIGH_LIMIT_RESET = 16'sd4000;

   localparam logic [15:0] RGB_BLACK   = 16'h0000;
   localparam logic [15:0] RGB_MAGENTA = 16'hF81F;

   // Highest palette segment; the colour above it is the last palette entry.
   localparam logic [2:0] SEG_LAST = 3'd4;

   // Palette: black, blue, green, yellow, red, magenta as {red, green, blue}.
   localparam logic [7:0] PALETTE [0:5][0:2] = '{
      '{8'd0,   8'd0,   8'd0},
      '{8'd0,   8'd0,   8'd255},
      '{8'd0,   8'd255, 8'd0},
      '{8'd255, 8'd255, 8'd0},
      '{8'd255, 8'd0,   8'd0},
      '{8'd255, 8'd0,   8'd255}
   };

   // Side data that travels with a word through the divider.
   typedef struct packed {
      logic [1:0]  clip;
      logic [15:0] divisor;
      logic [15:0] rem;
   } div_ctl_type;

endpackage

// ===== rtl/hfc_req_if.sv =====
interface hfc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_temp;

   modport source (output valid, output sample_temp, input ready);
   modport sink (input valid, input sample_temp, output ready);
endinterface

// ===== rtl/hfc_rsp_if.sv =====
interface hfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] rgb565;
   logic [1:0]  clip_status;

   modport source (output valid, output rgb565, output clip_status, input ready);
   modport sink (input valid, input rgb565, input clip_status, output ready);
endinterface

// ===== rtl/heatmap_false_color.sv =====
// Heatmap false colour: each word on the request channel carries one signed
// temperature in hundredths of a degree and produces exactly one RGB565 colour
// word with a clip status on the response channel, in order. A new word can be
// taken in every clock cycle unless back-pressure holds the pipeline. A word
// passes FRACTION_BITS + 6 register stages (14 at the default): the restoring
// divider spends one pipeline stage per quotient bit (FRACTION_BITS + 3
// stages), and there are two front stages and one blend stage. Every stage
// holds its word when the one after it is full and stalled, and empty stages
// are filled while later ones wait, so back-pressure loses and repeats
// nothing. The limits are written over the APB port: low_limit at byte
// address 0, high_limit at byte address 4, the low 16 bits of pwdata being
// taken; they should only be changed while no word is in flight.
module heatmap_false_color #(
   parameter int FRACTION_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   hfc_req_if.sink     req_chan,
   hfc_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import hfc_pkg::*;

   // Quotient width: three integer bits (segment 0 to 4) and the fraction.
   localparam int QW = FRACTION_BITS + 3;

   logic signed [15:0] low_limit_ff;
   logic signed [15:0] high_limit_ff;
   logic               csr_write;

   logic [QW:0]        div_valid;
   logic [QW:0]        div_ready;
   div_ctl_type        div_ctl  [0:QW];
   logic [QW-1:0]      div_word [0:QW];

   // Configuration registers. The register index is byte address bit 2; the
   // port never waits.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff  <= LOW_LIMIT_RESET;
         high_limit_ff <= HIGH_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_LOW_LIMIT:  low_limit_ff  <= pwdata[15:0];
            REG_HIGH_LIMIT: high_limit_ff <= pwdata[15:0];
            default:        low_limit_ff  <= low_limit_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_LOW_LIMIT:  prdata = {16'h0000, low_limit_ff};
         REG_HIGH_LIMIT: prdata = {16'h0000, high_limit_ff};
         default:        prdata = 32'h0000_0000;
      endcase
   end

   // Front: offset from the low limit, span of the range, clip decision and
   // the dividend for the normalisation.
   hfc_front #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .sample_temp (req_chan.sample_temp),
      .low_limit   (low_limit_ff),
      .high_limit  (high_limit_ff),
      .out_valid   (div_valid[0]),
      .out_ready   (div_ready[0]),
      .out_ctl     (div_ctl[0]),
      .out_word    (div_word[0])
   );

   // Divider: one quotient bit per stage. After the last stage the word holds
   // the segment in its top three bits and the fraction below.
   for (genvar i = 0; i < QW; i++) begin : g_div
      hfc_div_step #(
         .QW (QW)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[i]),
         .in_ready  (div_ready[i]),
         .in_ctl    (div_ctl[i]),
         .in_word   (div_word[i]),
         .out_valid (div_valid[i+1]),
         .out_ready (div_ready[i+1]),
         .out_ctl   (div_ctl[i+1]),
         .out_word  (div_word[i+1])
      );
   end

   // Blend between neighbouring palette colours and pack as 5-6-5. Its output
   // register is the response channel's register.
   hfc_blend #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_blend (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid[QW]),
      .in_ready   (div_ready[QW]),
      .in_clip    (div_ctl[QW].clip),
      .in_quot    (div_word[QW]),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_rgb565 (rsp_chan.rgb565),
      .out_clip   (rsp_chan.clip_status)
   );

endmodule

// ===== rtl/hfc_front.sv =====
module hfc_front #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic signed [15:0]         sample_temp,
   input  logic signed [15:0]         low_limit,
   input  logic signed [15:0]         high_limit,
   output logic                       out_valid,
   input  logic                       out_ready,
   output hfc_pkg::div_ctl_type       out_ctl,
   output logic [FRACTION_BITS+2:0]   out_word
);
   import hfc_pkg::*;

   localparam int QW = FRACTION_BITS + 3;

   logic               a_valid_ff;
   logic signed [16:0] diff_ff, diff_in;
   logic signed [16:0] range_ff, range_in;
   logic               a_load, b_load;

   logic               b_valid_ff;
   div_ctl_type        ctl_ff, ctl_in;
   logic [QW-1:0]      word_ff, word_in;
   logic [18:0]        times5;

   assign b_load   = !b_valid_ff || out_ready;
   assign a_load   = !a_valid_ff || b_load;
   assign in_ready = a_load;

   // First stage: distance of the sample above the low limit, and the span.
   assign diff_in  = 17'(sample_temp) - 17'(low_limit);
   assign range_in = 17'(high_limit) - 17'(low_limit);

   // Second stage: classify, and prepare the dividend d*5*2^F. Because d*5 < 8*r
   // in range, d*5 >> 3 is already a valid partial remainder, and the three low
   // bits of d*5 followed by F zeros are fed in one per divider step.
   assign times5 = {3'b000, diff_ff[15:0]} + {1'b0, diff_ff[15:0], 2'b00};

   always_comb begin
      ctl_in.divisor = range_ff[15:0];
      ctl_in.rem     = times5[18:3];
      word_in        = {times5[2:0], {FRACTION_BITS{1'b0}}};
      priority if (diff_ff <= 17'sd0) begin
         ctl_in.clip = CLIP_LOW;
      end else if (range_ff <= 17'sd0 || diff_ff >= range_ff) begin
         ctl_in.clip = CLIP_HIGH;
      end else begin
         ctl_in.clip = CLIP_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_load) begin
            a_valid_ff <= in_valid;
         end
         if (b_load) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         diff_ff  <= diff_in;
         range_ff <= range_in;
      end
      if (b_load) begin
         ctl_ff  <= ctl_in;
         word_ff <= word_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_word  = word_ff;

endmodule

// ===== rtl/hfc_div_step.sv =====
module hfc_div_step #(
   parameter int QW = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hfc_pkg::div_ctl_type in_ctl,
   input  logic [QW-1:0]        in_word,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hfc_pkg::div_ctl_type out_ctl,
   output logic [QW-1:0]        out_word
);
   import hfc_pkg::*;

   logic          valid_ff;
   div_ctl_type   ctl_ff, ctl_in;
   logic [QW-1:0] word_ff, word_in;
   logic [16:0]   rem_shift;
   logic [17:0]   trial;
   logic          fits;
   logic          load;

   assign load     = !valid_ff || out_ready;
   assign in_ready = load;

   // One restoring step: the next dividend bit leaves the top of the word and
   // the quotient bit enters at the bottom.
   assign rem_shift = {in_ctl.rem, in_word[QW-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, in_ctl.divisor};
   assign fits      = !trial[17];

   always_comb begin
      ctl_in.clip    = in_ctl.clip;
      ctl_in.divisor = in_ctl.divisor;
      ctl_in.rem     = fits ? trial[15:0] : rem_shift[15:0];
      word_in        = {in_word[QW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ctl_ff  <= ctl_in;
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_word  = word_ff;

endmodule

// ===== rtl/hfc_blend.sv =====
module hfc_blend #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [1:0]               in_clip,
   input  logic [FRACTION_BITS+2:0] in_quot,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [15:0]              out_rgb565,
   output logic [1:0]               out_clip
);
   import hfc_pkg::*;

   localparam int NW = FRACTION_BITS + 10;

   logic                     valid_ff;
   logic [15:0]              rgb_ff, rgb_in;
   logic [1:0]               clip_ff;
   logic                     load;
   logic [2:0]               seg_raw, seg;
   logic [FRACTION_BITS-1:0] frac;
   logic [7:0]               chan [0:2];

   assign load     = !valid_ff || out_ready;
   assign in_ready = load;

   assign seg_raw = in_quot[FRACTION_BITS+2:FRACTION_BITS];
   assign seg     = (seg_raw > SEG_LAST) ? SEG_LAST : seg_raw;
   assign frac    = in_quot[FRACTION_BITS-1:0];

   // Linear blend per channel; the sum is never negative, so the integer part
   // is taken straight from the bits above the fraction.
   always_comb begin
      logic [7:0]        c0, c1;
      logic signed [8:0] step;
      logic [NW-1:0]     base;
      logic signed [NW-1:0] num;
      for (int k = 0; k < 3; k++) begin
         c0      = PALETTE[seg][k];
         c1      = PALETTE[seg + 3'd1][k];
         step    = $signed({1'b0, c1}) - $signed({1'b0, c0});
         base    = NW'(c0) << FRACTION_BITS;
         num     = $signed(base)
                 + NW'(step) * $signed(NW'({1'b0, frac}));
         chan[k] = num[FRACTION_BITS+7:FRACTION_BITS];
      end
   end

   always_comb begin
      unique case (in_clip)
         CLIP_LOW:  rgb_in = RGB_BLACK;
         CLIP_HIGH: rgb_in = RGB_MAGENTA;
         default:   rgb_in = {chan[0][7:3], chan[1][7:2], chan[2][7:3]};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rgb_ff  <= rgb_in;
         clip_ff <= in_clip;
      end
   end

   assign out_valid  = valid_ff;
   assign out_rgb565 = rgb_ff;
   assign out_clip   = clip_ff;

endmodule
